@@ rtl/core/reverse_substring_search_core_assert.svh @@
// Assertion macros used by the reverse substring search core.
`ifndef REVERSE_SUBSTRING_SEARCH_CORE_ASSERT_SVH
`define REVERSE_SUBSTRING_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rss_pkg.sv @@
// Types and constants of the reverse substring search core.
`timescale 1ns / 1ps

package rss_pkg;

    localparam int PATTERN_W = 64;
    localparam int PLEN_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             overflow;
        logic [POS_W-1:0] position;
        logic             found;
    } t_result;

endpackage

@@ rtl/core/rss_match.sv @@
// Parallel compare of the newest text bytes against the pattern.
`timescale 1ns / 1ps

module rss_match
    import rss_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int HD          = 7,
    parameter int LW          = 4
) (
    input  logic [HD-1:0][BYTE_W-1:0] i_hist,
    input  logic [BYTE_W-1:0]         i_byte,
    input  logic [PATTERN_W-1:0]      i_pattern,
    input  logic [LW-1:0]             i_len,
    output logic                      o_hit
);

    // window[d]: text byte d places back from the incoming one
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] w_window;
    logic [MAX_PATTERN-1:0]             w_hit_by_len;
    logic [MAX_PATTERN-1:0]             w_len_sel;

    assign w_window[0] = i_byte;
    for (genvar d = 1; d < MAX_PATTERN; d++) begin : g_window
        assign w_window[d] = i_hist[d-1];
    end

    always_comb begin
        logic v_ok;
        v_ok = 1'b1;
        w_hit_by_len = '0;
        w_len_sel    = '0;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            v_ok = 1'b1;
            for (int d = 0; d < l; d++) begin
                if (w_window[d] != i_pattern[BYTE_W*(l-1-d) +: BYTE_W]) begin
                    v_ok = 1'b0;
                end
            end
            w_hit_by_len[l-1] = v_ok;
            w_len_sel[l-1]    = (i_len == LW'(l));
        end
    end

    assign o_hit = |(w_hit_by_len & w_len_sel);

endmodule

@@ rtl/core/rss_tracker.sv @@
// Per-text state: history, byte count, last match start and flags.
`timescale 1ns / 1ps

module rss_tracker
    import rss_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [BYTE_W-1:0]    i_byte,
    input  logic                 i_present,
    input  logic                 i_end,
    input  logic [PATTERN_W-1:0] i_pattern,
    input  logic [PLEN_W-1:0]    i_plen,
    output t_result              o_result
);

    localparam int HD  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int CW  = $clog2(MAX_TEXT + 1);
    localparam int CW1 = CW + 1;
    localparam int PW  = $clog2(MAX_TEXT);
    localparam int XW  = PW + POS_W;

    logic [HD-1:0][BYTE_W-1:0] r_hist, n_hist;
    logic [CW-1:0]             r_count, n_count;
    logic [PW-1:0]             r_last, n_last;
    logic                      r_seen, n_seen;
    logic                      r_ovf, n_ovf;

    logic [LW-1:0]  w_len;
    logic           w_full;
    logic           w_take;
    logic [CW1-1:0] w_count_inc;
    logic           w_len_ok;
    logic           w_cmp_hit;
    logic           w_hit;
    logic [PW-1:0]  w_start;
    logic           w_empty;
    logic [XW-1:0]  w_last_ext;

    assign w_len = (i_plen > PLEN_W'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(i_plen);

    rss_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .HD          (HD),
        .LW          (LW)
    ) u_match (
        .i_hist    (r_hist),
        .i_byte    (i_byte),
        .i_pattern (i_pattern),
        .i_len     (w_len),
        .o_hit     (w_cmp_hit)
    );

    assign w_full      = (r_count == CW'(MAX_TEXT));
    assign w_take      = i_present && !r_ovf && !w_full;
    assign w_count_inc = CW1'(r_count) + CW1'(1);
    assign w_len_ok    = (w_count_inc >= CW1'(w_len));
    assign w_hit       = w_take && w_len_ok && (w_len != '0) && w_cmp_hit;
    assign w_start     = PW'(w_count_inc - CW1'(w_len));

    always_comb begin
        n_hist  = r_hist;
        n_count = r_count;
        n_last  = w_hit ? w_start : r_last;
        n_seen  = r_seen | w_hit;
        n_ovf   = r_ovf | (i_present && !w_take);
        if (w_take) begin
            for (int k = HD - 1; k > 0; k--) begin
                n_hist[k] = r_hist[k-1];
            end
            n_hist[0] = i_byte;
            n_count   = CW'(w_count_inc);
        end
    end

    // Result as seen after this item's byte is taken
    assign w_empty    = (w_len == '0);
    assign w_last_ext = XW'(n_last);
    assign o_result.found    = w_empty || n_seen;
    assign o_result.position = (w_empty || !n_seen) ? '0 : w_last_ext[POS_W-1:0];
    assign o_result.overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_hist  <= '0;
            r_count <= '0;
            r_last  <= '0;
            r_seen  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            r_hist  <= n_hist;
            r_count <= n_count;
            r_last  <= n_last;
            r_seen  <= n_seen;
            r_ovf   <= n_ovf;
        end
    end

endmodule

@@ rtl/core/reverse_substring_search_core.sv @@
// Top level of the reverse substring search core.
`timescale 1ns / 1ps
// Usage:
//   Configure the pattern over the cfg channel while the core is idle:
//   index CFG_PATTERN_BYTES writes the 64-bit pattern (first char in byte 0),
//   index CFG_PATTERN_LENGTH writes the length from data[3:0] (0 = empty).
//   Stream text on the slave side, one byte per item in tdata; tuser = 1
//   marks that tdata carries a byte, tlast = 1 ends the text. A tlast item
//   with tuser = 0 is a bare end marker. Each tlast item yields one result
//   item on the master side: found, start of the last match, overflow flag.
// Throughput:
//   One item per cycle while no end item is held back (see Backpressure). An item
//   is compared and folded into the text state while it sits in the input register;
//   an end item's result lands in the output register at the edge that advances it.
//   The rate is set by the combinational window compare.
// Reset:
//   Synchronous, active low; clears pattern, length, text state and valids.
// Backpressure:
//   While a result waits in the output register, non-end items keep
//   flowing; an end item holds in the input register and tready drops until
//   the master side takes the waiting result.

module reverse_substring_search_core
    import rss_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [PATTERN_W-1:0]   i_cfg_data,
    // text stream in
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] text_byte
    input  logic                   i_s_axis_tuser,   // [0] byte_present
    input  logic                   i_s_axis_tlast,   // end_of_text
    // result stream out
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // [0] found, [16:1] match_position,
                                                     // [17] text_overflow, [23:18] zero
);

    logic [PATTERN_W-1:0] r_pattern;
    logic [PLEN_W-1:0]    r_plen;

    // input register
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_present;
    logic                 r_in_end;

    // output register
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_accept;
    t_result              w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_plen    <= i_cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the held item unless it ends a text and the result slot is busy
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_advance   = r_in_valid && (!r_in_end || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte    <= i_s_axis_tdata;
            r_in_present <= i_s_axis_tuser;
            r_in_end     <= i_s_axis_tlast;
        end
    end

    rss_tracker #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_byte    (r_in_byte),
        .i_present (r_in_present),
        .i_end     (r_in_end),
        .i_pattern (r_pattern),
        .i_plen    (r_plen),
        .o_result  (w_result)
    );

    // Load a result on each end item; drop valid once the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_end) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out);

`include "reverse_substring_search_core_assert.svh"

    `RSS_ASSERT_NOW(a_pos_zero_when_missing, o_m_axis_tvalid && !o_m_axis_tdata[0],
        o_m_axis_tdata[16:1] == '0, "match position nonzero without a match")
    `RSS_ASSERT_NOW(a_stall_only_on_end, !o_s_axis_tready,
        r_in_valid && r_in_end && r_out_valid && !i_m_axis_tready,
        "input stalled without a blocked end item")
    `RSS_ASSERT_NEXT(a_result_from_end, !(w_advance && r_in_end) && !r_out_valid,
        !r_out_valid, "result valid without an end item")

endmodule

@@ tb/sv/tb_reverse_substring_search_core.sv @@
// Self-checking testbench of the reverse substring search core.
`timescale 1ns / 1ps

module tb_reverse_substring_search_core;
    import rss_pkg::*;

    localparam int          PAT_MAX       = 8;
    localparam int          TEXT_MAX      = 65536;
    localparam int          RES_W         = $bits(t_result);
    localparam int          SETTLE_CYCLES = 4;       // margin after the last answered text end
    localparam int          RANDOM_ITEMS  = 1450;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    typedef enum {END_ON_BYTE, END_BARE, END_NONE} t_text_end;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_idx               i_cfg_index = CFG_PATTERN_BYTES;
    logic [PATTERN_W-1:0]   i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [BYTE_W-1:0]      i_s_axis_tdata = '0;   // [7:0] text_byte
    logic                   i_s_axis_tuser = 1'b0; // [0] byte_present
    logic                   i_s_axis_tlast = 1'b0; // end_of_text
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // [0] found, [16:1] match_position,
                                                   // [17] text_overflow, [23:18] zero

    reverse_substring_search_core #(
        .MAX_PATTERN(PAT_MAX),
        .MAX_TEXT   (TEXT_MAX)
    ) dut (.*);

    // Tracks the text state, predicts the result of every text end and
    // checks the result items in order.
    class match_tracker;
        bit [PATTERN_W-1:0] pat;
        bit [PLEN_W-1:0]    plen;
        bit [BYTE_W-1:0]    history [0:PAT_MAX-1];
        int unsigned        text_len;
        int unsigned        latest_start;
        bit                 seen;
        bit                 frozen;
        t_result            pending_results[$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        found_count;
        int unsigned        overflow_count;

        function void set_register(t_cfg_idx idx, bit [PATTERN_W-1:0] value);
            case (idx)
                CFG_PATTERN_BYTES:  pat  = value;
                CFG_PATTERN_LENGTH: plen = value[PLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned used_len();
            return (plen > PAT_MAX) ? PAT_MAX : plen;
        endfunction

        function void clear_text();
            foreach (history[k]) history[k] = '0;
            text_len     = 0;
            latest_start = 0;
            seen         = 1'b0;
            frozen       = 1'b0;
        endfunction

        function void shift_in(bit [BYTE_W-1:0] b);
            int unsigned n;
            bit          hit;
            n = used_len();
            // freeze once the position range is used up
            if (frozen || text_len >= TEXT_MAX) begin
                frozen = 1'b1;
                return;
            end
            if (n > 0 && text_len + 1 >= n) begin
                hit = (pat[(n-1)*8 +: 8] == b);
                for (int k = 0; k + 1 < n; k++)
                    if (pat[k*8 +: 8] != history[n-2-k])
                        hit = 1'b0;
                if (hit) begin
                    latest_start = text_len + 1 - n;
                    seen         = 1'b1;
                end
            end
            for (int k = PAT_MAX - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = b;
            text_len++;
        endfunction

        function void take_text_item(bit [BYTE_W-1:0] b, bit present, bit last);
            t_result r;
            bit      empty;
            if (present)
                shift_in(b);
            if (!last)
                return;
            empty      = (used_len() == 0);
            r.found    = empty || seen;
            r.position = (empty || !seen) ? '0 : latest_start[POS_W-1:0];
            r.overflow = frozen;
            pending_results.push_back(r);
            clear_text();
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            t_result want;
            t_result got;
            if (pending_results.size() == 0) begin
                $error("result item with no text end pending: tdata=%h", data);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            got  = t_result'(data[RES_W-1:0]);
            results_checked++;
            found_count    += want.found;
            overflow_count += want.overflow;
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("match_position: expected %0d, got %0d", want.position, got.position);
                mismatches++;
            end
            if (got.overflow !== want.overflow) begin
                $error("text_overflow: expected %0d, got %0d", want.overflow, got.overflow);
                mismatches++;
            end
            if (data[OUT_TDATA_W-1:RES_W] !== '0) begin
                $error("tdata pad: expected 0, got %h", data[OUT_TDATA_W-1:RES_W]);
                mismatches++;
            end
        endfunction

        function void flag_leftovers();
            foreach (pending_results[k]) begin
                $error("text end never answered: found=%0d position=%0d overflow=%0d",
                       pending_results[k].found, pending_results[k].position,
                       pending_results[k].overflow);
                mismatches++;
            end
        endfunction
    endclass

    match_tracker      board = new();
    bit                steady = 1'b0;     // no idling on either side while set
    int unsigned       text_items = 0;
    int unsigned       cfg_writes = 0;
    int unsigned       cycle_count = 0;
    bit [PATTERN_W-1:0] cur_pat;
    bit [PLEN_W-1:0]   cur_len;
    bit [BYTE_W-1:0]   alphabet [3];

    initial forever #2 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Accept result items under random stalls.
    initial begin : result_sink
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata);
            if (stall != 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else if (!steady && $urandom_range(99) < 20) begin
                stall = pick_gap();
                i_m_axis_tready <= (stall == 0);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input bit [PATTERN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, value);
        cfg_writes++;
    endtask

    // Write both registers in random order; junk above the length nibble.
    task automatic load_pattern(input bit [PATTERN_W-1:0] pat, input bit [PLEN_W-1:0] len);
        bit [PATTERN_W-1:0] len_word;
        len_word           = {$urandom, $urandom};
        len_word[PLEN_W-1:0] = len;
        if ($urandom_range(1)) begin
            write_reg(CFG_PATTERN_BYTES, pat);
            write_reg(CFG_PATTERN_LENGTH, len_word);
        end else begin
            write_reg(CFG_PATTERN_LENGTH, len_word);
            write_reg(CFG_PATTERN_BYTES, pat);
        end
        i_cfg_valid <= 1'b0;
        cur_pat = pat;
        cur_len = len;
    endtask

    task automatic load_random_pattern();
        bit [PATTERN_W-1:0] pat;
        bit [PLEN_W-1:0]    len;
        int unsigned        r;
        foreach (alphabet[j]) alphabet[j] = 8'($urandom);
        r = $urandom_range(99);
        if (r < 8)
            len = '0;
        else if (r < 15)
            len = PLEN_W'($urandom_range(9, 15));
        else if (r < 35)
            len = PLEN_W'($urandom_range(5, 8));
        else
            len = PLEN_W'($urandom_range(1, 4));
        for (int k = 0; k < PAT_MAX; k++)
            pat[k*8 +: 8] = alphabet[$urandom_range(2)];
        if ($urandom_range(99) < 5)
            pat = {$urandom, $urandom};
        load_pattern(pat, len);
    endtask

    // Hold the sender and wait until every text end has been answered.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input bit [BYTE_W-1:0] b, input bit present, input bit last,
                             input int unsigned gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= present;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.take_text_item(b, present, last);
        if (present || last)
            text_items++;
    endtask

    task automatic send_text(input bit [BYTE_W-1:0] txt[$], input t_text_end closing,
                             input int unsigned idle_pct, input bit paced);
        int unsigned n;
        n = txt.size();
        if (closing == END_ON_BYTE && n == 0)
            closing = END_BARE;
        for (int unsigned k = 0; k < n; k++) begin
            if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                send_item(8'($urandom), 1'b0, 1'b0, paced ? pick_gap() : 0);
            send_item(txt[k], 1'b1, closing == END_ON_BYTE && k + 1 == n,
                      paced ? pick_gap() : 0);
        end
        if (closing == END_BARE)
            send_item(8'($urandom), 1'b0, 1'b1, paced ? pick_gap() : 0);
    endtask

    // Mix whole pattern copies, broken prefixes, alphabet noise and random bytes.
    task automatic build_text(output bit [BYTE_W-1:0] txt[$]);
        int unsigned want_len;
        int unsigned eff;
        int unsigned r;
        int unsigned cut;
        txt.delete();
        want_len = ($urandom_range(99) < 10) ? $urandom_range(25, 60) : $urandom_range(0, 20);
        eff      = (cur_len > PAT_MAX) ? PAT_MAX : cur_len;
        while (txt.size() < want_len) begin
            r = $urandom_range(99);
            if (r < 35) begin
                for (int k = 0; k < eff; k++) txt.push_back(cur_pat[k*8 +: 8]);
            end else if (r < 45) begin
                cut = $urandom_range(eff);
                for (int k = 0; k < cut; k++) txt.push_back(cur_pat[k*8 +: 8]);
            end else if (r < 50) begin
                txt.push_back(8'($urandom));
            end else begin
                txt.push_back(alphabet[$urandom_range(2)]);
            end
        end
        while (txt.size() > want_len) void'(txt.pop_back());
    endtask

    initial begin : stimulus
        bit [BYTE_W-1:0] txt[$];
        bit [BYTE_W-1:0] head[$];
        bit [BYTE_W-1:0] tail[$];
        int unsigned     target;
        int unsigned     cut;
        t_text_end       closing;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern straight after reset: found at 0, bare end marker
        send_item(8'h61, 1'b1, 1'b0, 0);
        send_item(8'h00, 1'b0, 1'b1, 0);
        drain();

        // "ab": last of two matches, an idle item inside, end on a byte
        load_pattern(64'h6261, 4'd2);
        send_item(8'h78, 1'b1, 1'b0, 0);
        send_item(8'h61, 1'b1, 1'b0, 1);
        send_item(8'h00, 1'b0, 1'b0, 0);
        send_item(8'h62, 1'b1, 1'b0, 2);
        send_item(8'h61, 1'b1, 1'b0, 0);
        send_item(8'h62, 1'b1, 1'b1, 0);
        // empty text: not found
        send_item(8'hff, 1'b0, 1'b1, 0);
        drain();

        // zero pattern bytes and zero text bytes; length 15 clamps to 8
        load_pattern(64'h0, 4'd15);
        for (int i = 0; i < 9; i++)
            send_item(8'h00, 1'b1, i == 8, 0);
        drain();

        // all-ones pattern longer than the text
        load_pattern('1, 4'd3);
        send_item(8'hff, 1'b1, 1'b0, 0);
        send_item(8'hff, 1'b1, 1'b1, 0);
        drain();

        // pattern swapped mid-text: the early "cd" match must survive
        load_pattern(64'h6463, 4'd2);
        send_item(8'h63, 1'b1, 1'b0, 0);
        send_item(8'h64, 1'b1, 1'b0, 0);
        drain();
        load_pattern(64'h71, 4'd1);
        send_item(8'h63, 1'b1, 1'b0, 0);
        send_item(8'h64, 1'b1, 1'b1, 0);
        drain();

        // random texts, now and then a new pattern or one swapped mid-text
        load_random_pattern();
        target = text_items + RANDOM_ITEMS;
        while (text_items < target) begin
            if ($urandom_range(99) < 5)
                steady = !steady;
            if ($urandom_range(99) < 30) begin
                drain();
                load_random_pattern();
            end
            build_text(txt);
            closing = $urandom_range(1) ? END_ON_BYTE : END_BARE;
            if (txt.size() > 1 && $urandom_range(99) < 6) begin
                cut  = $urandom_range(1, txt.size() - 1);
                head = txt[0:cut-1];
                tail = txt[cut:$];
                send_text(head, END_NONE, 4, 1'b1);
                drain();
                load_random_pattern();
                send_text(tail, closing, 4, 1'b1);
            end else begin
                send_text(txt, closing, 4, 1'b1);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        board.flag_leftovers();
        $display("Checked %0d results from %0d text items, %0d register writes, %0d cycles",
                 board.results_checked, text_items, cfg_writes, cycle_count);
        $display("Results with a match: %0d, with overflow: %0d",
                 board.found_count, board.overflow_count);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rss_pkg.sv
rtl/core/rss_match.sv
rtl/core/rss_tracker.sv
rtl/core/reverse_substring_search_core.sv
tb/sv/tb_reverse_substring_search_core.sv
